// ===== rtl/cmx_pkg.sv =====
// Shared types, codes and operand schedule of the 2x2 complex matrix unit.
package cmx_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Operation selector
  typedef enum logic [2:0] {
    FN_LOAD = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_CSC  = 3'd4,
    FN_RSC  = 3'd5,
    FN_DET  = 3'd6,
    FN_INV  = 3'd7
  } func_e;

  // Product sequence being run by the shared multiplier
  typedef enum logic [1:0] {
    PH_OP   = 2'd0,
    PH_IDET = 2'd1,
    PH_FDET = 2'd2,
    PH_NORM = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SIMPLE,
    S_MAC,
    S_WAIT,
    S_CHKSING,
    S_DIVGO,
    S_DIVRUN,
    S_ADJ,
    S_PUBLISH
  } state_e;

  // Operand source codes: [4:3] bank, [2:0] entry
  localparam logic [4:0] SRC_ACC  = 5'd0;
  localparam logic [4:0] SRC_X    = 5'd8;
  localparam logic [4:0] SRC_M    = 5'd16;
  localparam logic [4:0] SRC_RR   = 5'd24;
  localparam logic [4:0] SRC_RI   = 5'd25;
  localparam logic [4:0] SRC_DRE  = 5'd26;
  localparam logic [4:0] SRC_DIM  = 5'd27;
  localparam logic [4:0] SRC_ZERO = 5'd28;

  localparam logic [4:0] K_LAST_OP   = 5'd31;
  localparam logic [4:0] K_LAST_DET  = 5'd7;
  localparam logic [4:0] K_LAST_NORM = 5'd3;

  typedef struct packed {
    logic       neg;
    logic [4:0] sa;
    logic [4:0] sb;
  } term_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       cap;
    logic       simple;
    logic       set_sing;
    logic       adj;
    logic       div_start;
    logic       issue;
    logic       publish;
    phase_e     phase;
    logic [4:0] k;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_e func;
    logic  det_zero;
    logic  div_done;
  } stat_t;

  // Operands and sign of product term k (result part k[4:2], term k[1:0])
  function automatic term_t term_sel(phase_e ph, func_e fn, logic [4:0] k);
    logic [2:0] o;
    logic [1:0] t;
    logic [1:0] e;
    logic [4:0] p0;
    logic [4:0] p1;
    logic [4:0] q0;
    logic [4:0] q1;
    logic [4:0] eb;
    logic [4:0] db;
    term_t      r;
    o  = k[4:2];
    t  = k[1:0];
    e  = o[2:1];
    p0 = {2'b00, e[1], 2'b00};
    p1 = p0 + 5'd2;
    q0 = {3'b000, e[0], 1'b0};
    q1 = q0 + 5'd4;
    eb = {2'b00, e, 1'b0};
    db = (ph == PH_FDET) ? SRC_M : SRC_ACC;
    r.neg = 1'b0;
    r.sa  = SRC_ZERO;
    r.sb  = SRC_ZERO;
    unique case (ph)
      PH_OP: begin
        unique case (fn)
          FN_MUL: begin
            unique case (t)
              2'd0: begin
                r.sa = SRC_ACC + p0;
                r.sb = o[0] ? SRC_X + q0 + 5'd1 : SRC_X + q0;
              end
              2'd1: begin
                r.sa  = SRC_ACC + p0 + 5'd1;
                r.sb  = o[0] ? SRC_X + q0 : SRC_X + q0 + 5'd1;
                r.neg = ~o[0];
              end
              2'd2: begin
                r.sa = SRC_ACC + p1;
                r.sb = o[0] ? SRC_X + q1 + 5'd1 : SRC_X + q1;
              end
              default: begin
                r.sa  = SRC_ACC + p1 + 5'd1;
                r.sb  = o[0] ? SRC_X + q1 : SRC_X + q1 + 5'd1;
                r.neg = ~o[0];
              end
            endcase
          end
          FN_CSC, FN_INV: begin
            if (t == 2'd0) begin
              r.sa = (fn == FN_INV) ? SRC_X + eb : SRC_ACC + eb;
              if (fn == FN_INV) r.sb = o[0] ? SRC_RI : SRC_RR;
              else r.sb = o[0] ? SRC_X + 5'd1 : SRC_X;
            end else if (t == 2'd1) begin
              r.sa  = (fn == FN_INV) ? SRC_X + eb + 5'd1 : SRC_ACC + eb + 5'd1;
              if (fn == FN_INV) r.sb = o[0] ? SRC_RR : SRC_RI;
              else r.sb = o[0] ? SRC_X : SRC_X + 5'd1;
              r.neg = ~o[0];
            end
          end
          FN_RSC: begin
            if (t == 2'd0) begin
              r.sa = SRC_ACC + {2'b00, o};
              r.sb = SRC_X;
            end
          end
          default: begin
            r.neg = 1'b0;
          end
        endcase
      end
      PH_IDET, PH_FDET: begin
        unique case (t)
          2'd0: begin
            r.sa = db;
            r.sb = o[0] ? db + 5'd7 : db + 5'd6;
          end
          2'd1: begin
            r.sa  = db + 5'd1;
            r.sb  = o[0] ? db + 5'd6 : db + 5'd7;
            r.neg = ~o[0];
          end
          2'd2: begin
            r.sa  = db + 5'd2;
            r.sb  = o[0] ? db + 5'd5 : db + 5'd4;
            r.neg = 1'b1;
          end
          default: begin
            r.sa  = db + 5'd3;
            r.sb  = o[0] ? db + 5'd4 : db + 5'd5;
            r.neg = o[0];
          end
        endcase
      end
      default: begin
        if (t == 2'd0) begin
          r.sa = SRC_DRE;
          r.sb = SRC_DRE;
        end else if (t == 2'd1) begin
          r.sa = SRC_DIM;
          r.sb = SRC_DIM;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cmx_recip.sv =====
// Restoring divider forming both saturated parts of the determinant reciprocal.
module cmx_recip #(
  parameter int unsigned WORD_BITS = cmx_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = cmx_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2*WORD_BITS-1:0]        norm_i,
  input  logic [WORD_BITS-1:0]          mag_re_i,
  input  logic [WORD_BITS-1:0]          mag_im_i,
  input  logic                          neg_re_i,
  input  logic                          neg_im_i,
  output logic                          done_o,
  output logic signed [WORD_BITS-1:0]   rr_o,
  output logic signed [WORD_BITS-1:0]   ri_o,
  output logic                          ovf_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned QB = WORD_BITS + 2 * FRAC_BITS;
  localparam int unsigned CB = $clog2(QB);
  localparam logic [CB-1:0] CNT_LAST = CB'(QB - 1);

  logic [2*W-1:0] norm_q;
  logic [QB-1:0]  num_re_q, num_re_d, num_im_q, num_im_d;
  logic [QB-1:0]  quo_re_q, quo_re_d, quo_im_q, quo_im_d;
  logic [2*W-1:0] rem_re_q, rem_re_d, rem_im_q, rem_im_d;
  logic           neg_re_q, neg_im_q;
  logic [CB-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic           ovf_re, ovf_im;

  // One quotient bit of one part
  function automatic logic [2*W:0] div_step(logic [2*W-1:0] rem, logic nb,
                                            logic [2*W-1:0] den);
    logic [2*W:0] trial;
    logic         ge;
    trial = {rem, nb};
    ge    = (trial >= {1'b0, den});
    if (ge) trial = trial - {1'b0, den};
    return {ge, trial[2*W-1:0]};
  endfunction

  // Saturate a quotient magnitude with its sign into a word
  function automatic logic [W:0] sat_q(logic [QB-1:0] q, logic neg);
    logic         big;
    logic [W-1:0] v;
    if (neg) begin
      big = (|q[QB-1:W]) | (q[W-1] & (|q[W-2:0]));
      v   = big ? {1'b1, {(W-1){1'b0}}} : (~q[W-1:0]) + W'(1);
    end else begin
      big = |q[QB-1:W-1];
      v   = big ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
    end
    return {big, v};
  endfunction

  // Advance both parts one bit
  always_comb begin
    logic [2*W:0] sr;
    logic [2*W:0] si;
    sr       = div_step(rem_re_q, num_re_q[QB-1], norm_q);
    si       = div_step(rem_im_q, num_im_q[QB-1], norm_q);
    rem_re_d = sr[2*W-1:0];
    rem_im_d = si[2*W-1:0];
    quo_re_d = {quo_re_q[QB-2:0], sr[2*W]};
    quo_im_d = {quo_im_q[QB-2:0], si[2*W]};
    num_re_d = {num_re_q[QB-2:0], 1'b0};
    num_im_d = {num_im_q[QB-2:0], 1'b0};
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CB'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      norm_q   <= norm_i;
      num_re_q <= {mag_re_i, {(2*FRAC_BITS){1'b0}}};
      num_im_q <= {mag_im_i, {(2*FRAC_BITS){1'b0}}};
      rem_re_q <= '0;
      rem_im_q <= '0;
      quo_re_q <= '0;
      quo_im_q <= '0;
      neg_re_q <= neg_re_i;
      neg_im_q <= neg_im_i;
    end else if (busy_q) begin
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      quo_re_q <= quo_re_d;
      quo_im_q <= quo_im_d;
    end
  end

  assign {ovf_re, rr_o} = sat_q(quo_re_q, neg_re_q);
  assign {ovf_im, ri_o} = sat_q(quo_im_q, neg_im_q);
  assign ovf_o  = ovf_re | ovf_im;
  assign done_o = done_q;

endmodule

// ===== rtl/cmx_datapath.sv =====
// Accumulator, operand banks, shared multiplier with summing stage, and result registers.
module cmx_datapath #(
  parameter int unsigned WORD_BITS = cmx_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = cmx_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmx_pkg::cmd_t               cmd_i,
  output cmx_pkg::stat_t              stat_o,
  input  logic [2:0]                  func_i,
  input  logic signed [WORD_BITS-1:0] in_x_i [8],
  output logic signed [WORD_BITS-1:0] out_m_o [8],
  output logic signed [WORD_BITS-1:0] out_det_re_o,
  output logic signed [WORD_BITS-1:0] out_det_im_o,
  output logic                        out_ovf_o,
  output logic                        out_sing_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned SW = 2 * W - F + 2;
  localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] W_ONE = W'(1) << F;

  cmx_pkg::func_e func_q;
  logic signed [W-1:0] acc_q [8];
  logic signed [W-1:0] x_q [8];
  logic signed [W-1:0] m_q [8];
  logic signed [W-1:0] dre_q, dim_q;
  logic [2*W-1:0]      norm_q;
  logic                ovf_q, sing_q;

  logic signed [W-1:0] simple_v [8];
  logic [7:0]          simple_ovf;
  logic signed [W-1:0] neg_v [8];
  logic [7:0]          neg_ovf;

  cmx_pkg::term_t      tsel;
  logic signed [W-1:0] op_a, op_b;

  logic                p_valid_q, p_neg_q, p_first_q, p_last_q;
  cmx_pkg::phase_e     p_phase_q;
  logic [2:0]          p_o_q;
  logic signed [2*W-1:0] prod_q;
  logic signed [SW-1:0]  sum_q, sum_d, term_v;
  logic signed [2*W-F-1:0] sh;
  logic                sum_ok;
  logic signed [W-1:0] sum_sat;
  logic                wr_fix;

  logic                div_done, div_ovf;
  logic signed [W-1:0] rr, ri;
  logic [W-1:0]        mag_re, mag_im;

  // Pick a multiplier operand by source code
  function automatic logic signed [W-1:0] src_rd(
      logic [4:0] s, logic signed [W-1:0] a [8], logic signed [W-1:0] x [8],
      logic signed [W-1:0] m [8], logic signed [W-1:0] r0, logic signed [W-1:0] r1,
      logic signed [W-1:0] d0, logic signed [W-1:0] d1);
    logic signed [W-1:0] v;
    unique case (s[4:3])
      2'd0: v = a[s[2:0]];
      2'd1: v = x[s[2:0]];
      2'd2: v = m[s[2:0]];
      default: begin
        unique case (s[2:0])
          3'd0: v = r0;
          3'd1: v = r1;
          3'd2: v = d0;
          3'd3: v = d1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  // Load, add, subtract or copy, and the adjugate negations
  always_comb begin
    logic signed [W:0] s;
    for (int i = 0; i < 8; i++) begin
      unique case (func_q)
        cmx_pkg::FN_LOAD: s = {x_q[i][W-1], x_q[i]};
        cmx_pkg::FN_ADD:  s = {acc_q[i][W-1], acc_q[i]} + {x_q[i][W-1], x_q[i]};
        cmx_pkg::FN_SUB:  s = {acc_q[i][W-1], acc_q[i]} - {x_q[i][W-1], x_q[i]};
        default:          s = {acc_q[i][W-1], acc_q[i]};
      endcase
      simple_ovf[i] = s[W] ^ s[W-1];
      simple_v[i]   = simple_ovf[i] ? (s[W] ? W_MIN : W_MAX) : s[W-1:0];
      neg_ovf[i]    = (acc_q[i] == W_MIN);
      neg_v[i]      = neg_ovf[i] ? W_MAX : -acc_q[i];
    end
  end

  // Select operands for the issued term
  always_comb begin
    tsel = cmx_pkg::term_sel(cmd_i.phase, func_q, cmd_i.k);
    op_a = src_rd(tsel.sa, acc_q, x_q, m_q, rr, ri, dre_q, dim_q);
    op_b = src_rd(tsel.sb, acc_q, x_q, m_q, rr, ri, dre_q, dim_q);
  end

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q    <= op_a * op_b;
      p_neg_q   <= tsel.neg;
      p_first_q <= (cmd_i.k[1:0] == 2'd0);
      p_last_q  <= (cmd_i.k[1:0] == 2'd3);
      p_phase_q <= cmd_i.phase;
      p_o_q     <= cmd_i.k[4:2];
    end
  end

  // Sum shifted products and saturate the finished part
  always_comb begin
    sh      = prod_q[2*W-1:F];
    term_v  = p_neg_q ? -SW'(sh) : SW'(sh);
    sum_d   = (p_first_q ? '0 : sum_q) + term_v;
    sum_ok  = (&sum_d[SW-1:W-1]) | ~(|sum_d[SW-1:W-1]);
    sum_sat = sum_ok ? sum_d[W-1:0] : (sum_d[SW-1] ? W_MIN : W_MAX);
    wr_fix  = p_valid_q && p_last_q && (p_phase_q != cmx_pkg::PH_NORM);
  end

  // Hold input matrix, adjugate, results and flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      func_q <= cmx_pkg::func_e'(func_i);
      for (int i = 0; i < 8; i++) x_q[i] <= in_x_i[i];
    end else if (cmd_i.adj) begin
      x_q[0] <= acc_q[6];
      x_q[1] <= acc_q[7];
      x_q[6] <= acc_q[0];
      x_q[7] <= acc_q[1];
      for (int i = 2; i < 6; i++) x_q[i] <= neg_v[i];
    end

    if (cmd_i.simple) begin
      for (int i = 0; i < 8; i++) m_q[i] <= simple_v[i];
    end

    if (p_valid_q && p_phase_q != cmx_pkg::PH_NORM) sum_q <= sum_d;

    if (wr_fix) begin
      unique case (p_phase_q)
        cmx_pkg::PH_OP: m_q[p_o_q] <= sum_sat;
        default: begin
          if (p_o_q[0]) dim_q <= sum_sat;
          else dre_q <= sum_sat;
        end
      endcase
    end

    if (p_valid_q && p_phase_q == cmx_pkg::PH_NORM) begin
      norm_q <= (p_first_q ? '0 : norm_q) + prod_q;
    end

    if (cmd_i.cap) begin
      ovf_q  <= 1'b0;
      sing_q <= 1'b0;
    end else begin
      if ((cmd_i.simple && (|simple_ovf)) || (cmd_i.adj && (|neg_ovf[5:2])) ||
          (wr_fix && !sum_ok) || (div_done && div_ovf)) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.set_sing) sing_q <= 1'b1;
    end

    if (cmd_i.publish) begin
      for (int i = 0; i < 8; i++) out_m_o[i] <= m_q[i];
      out_det_re_o <= dre_q;
      out_det_im_o <= dim_q;
      out_ovf_o    <= ovf_q;
      out_sing_o   <= sing_q;
    end
  end

  // Accumulator: identity after reset, takes the new matrix on publish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) acc_q[i] <= '0;
      acc_q[0] <= W_ONE;
      acc_q[6] <= W_ONE;
    end else if (cmd_i.publish) begin
      for (int i = 0; i < 8; i++) acc_q[i] <= m_q[i];
    end
  end

  // Reciprocal of the determinant
  assign mag_re = dre_q[W-1] ? W'(-dre_q) : W'(dre_q);
  assign mag_im = dim_q[W-1] ? W'(-dim_q) : W'(dim_q);

  cmx_recip #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .norm_i   (norm_q),
    .mag_re_i (mag_re),
    .mag_im_i (mag_im),
    .neg_re_i (dre_q[W-1]),
    .neg_im_i (!dim_q[W-1] && (dim_q != '0)),
    .done_o   (div_done),
    .rr_o     (rr),
    .ri_o     (ri),
    .ovf_o    (div_ovf)
  );

  assign stat_o.func     = func_q;
  assign stat_o.det_zero = (dre_q == '0) && (dim_q == '0);
  assign stat_o.div_done = div_done;

endmodule

// ===== rtl/cmx_ctrl.sv =====
// Sequencer that steps the datapath through one request and owns both handshakes.
module cmx_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cmx_pkg::stat_t stat_i,
  output cmx_pkg::cmd_t  cmd_o
);

  cmx_pkg::state_e state_q, state_d;
  cmx_pkg::phase_e phase_q, phase_d;
  logic [4:0]      k_q, k_d;
  logic            out_valid_q, out_valid_d;
  logic [4:0]      k_last;
  logic            slot_free;

  always_comb begin
    unique case (phase_q)
      cmx_pkg::PH_OP:   k_last = cmx_pkg::K_LAST_OP;
      cmx_pkg::PH_NORM: k_last = cmx_pkg::K_LAST_NORM;
      default:          k_last = cmx_pkg::K_LAST_DET;
    endcase
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    unique case (state_q)
      cmx_pkg::S_IDLE: begin
        if (in_valid_i) state_d = cmx_pkg::S_DISPATCH;
      end
      cmx_pkg::S_DISPATCH: begin
        k_d = '0;
        unique case (stat_i.func)
          cmx_pkg::FN_MUL, cmx_pkg::FN_CSC, cmx_pkg::FN_RSC: begin
            state_d = cmx_pkg::S_MAC;
            phase_d = cmx_pkg::PH_OP;
          end
          cmx_pkg::FN_INV: begin
            state_d = cmx_pkg::S_MAC;
            phase_d = cmx_pkg::PH_IDET;
          end
          default: state_d = cmx_pkg::S_SIMPLE;
        endcase
      end
      cmx_pkg::S_SIMPLE: begin
        state_d = cmx_pkg::S_MAC;
        phase_d = cmx_pkg::PH_FDET;
        k_d     = '0;
      end
      cmx_pkg::S_MAC: begin
        k_d = k_q + 5'd1;
        if (k_q == k_last) state_d = cmx_pkg::S_WAIT;
      end
      cmx_pkg::S_WAIT: begin
        k_d = '0;
        unique case (phase_q)
          cmx_pkg::PH_OP: begin
            state_d = cmx_pkg::S_MAC;
            phase_d = cmx_pkg::PH_FDET;
          end
          cmx_pkg::PH_IDET: state_d = cmx_pkg::S_CHKSING;
          cmx_pkg::PH_NORM: state_d = cmx_pkg::S_DIVGO;
          default:          state_d = cmx_pkg::S_PUBLISH;
        endcase
      end
      cmx_pkg::S_CHKSING: begin
        k_d = '0;
        if (stat_i.det_zero) begin
          state_d = cmx_pkg::S_SIMPLE;
        end else begin
          state_d = cmx_pkg::S_MAC;
          phase_d = cmx_pkg::PH_NORM;
        end
      end
      cmx_pkg::S_DIVGO: state_d = cmx_pkg::S_DIVRUN;
      cmx_pkg::S_DIVRUN: begin
        if (stat_i.div_done) state_d = cmx_pkg::S_ADJ;
      end
      cmx_pkg::S_ADJ: begin
        state_d = cmx_pkg::S_MAC;
        phase_d = cmx_pkg::PH_OP;
        k_d     = '0;
      end
      cmx_pkg::S_PUBLISH: begin
        if (slot_free) state_d = cmx_pkg::S_IDLE;
      end
      default: state_d = cmx_pkg::S_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.phase     = phase_q;
    cmd_o.k         = k_q;
    cmd_o.cap       = (state_q == cmx_pkg::S_IDLE) && in_valid_i;
    cmd_o.simple    = (state_q == cmx_pkg::S_SIMPLE);
    cmd_o.set_sing  = (state_q == cmx_pkg::S_CHKSING) && stat_i.det_zero;
    cmd_o.adj       = (state_q == cmx_pkg::S_ADJ);
    cmd_o.div_start = (state_q == cmx_pkg::S_DIVGO);
    cmd_o.issue     = (state_q == cmx_pkg::S_MAC);
    cmd_o.publish   = (state_q == cmx_pkg::S_PUBLISH) && slot_free;
    in_ready_o      = (state_q == cmx_pkg::S_IDLE);
    out_valid_d     = cmd_o.publish ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmx_pkg::S_IDLE;
      phase_q     <= cmx_pkg::PH_OP;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/complex_2x2_matrix_alu_core.sv =====
// Top level of the accumulating 2x2 complex matrix unit.
// Multiply and both scales run 32 product terms and 8 determinant terms on one shared
// multiplier; inverse also waits on the bit-serial reciprocal divider (Q15.16 by default);
// a singular inverse skips the divider. One request is in work at a time, the next taken
// the cycle after a result registers. Reset loads identity, empties the output.
module complex_2x2_matrix_alu_core #(
  parameter int unsigned WORD_BITS = cmx_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = cmx_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_BITS  = ((8 * WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ((10 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // in_a_re, in_a_im, in_b_re, in_b_im, in_c_re, in_c_im, in_d_re, in_d_im
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  // func
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_a_re, out_a_im, out_b_re, out_b_im, out_c_re, out_c_im, out_d_re, out_d_im,
  // det_re, det_im
  output logic [OUT_BITS-1:0] m_axis_tdata,
  // overflow, singular
  output logic [1:0]          m_axis_tuser
);

  localparam int unsigned W = WORD_BITS;

  cmx_pkg::cmd_t       cmd;
  cmx_pkg::stat_t      stat;
  logic signed [W-1:0] in_x [8];
  logic signed [W-1:0] out_m [8];
  logic signed [W-1:0] det_re, det_im;
  logic                ovf, sing;

  // Unpack and pack the stream words
  always_comb begin
    for (int i = 0; i < 8; i++) in_x[i] = s_axis_tdata[i*W +: W];
    m_axis_tdata = '0;
    for (int i = 0; i < 8; i++) m_axis_tdata[i*W +: W] = out_m[i];
    m_axis_tdata[8*W +: W] = det_re;
    m_axis_tdata[9*W +: W] = det_im;
  end

  assign m_axis_tuser = {sing, ovf};

  cmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cmx_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (s_axis_tuser),
    .in_x_i       (in_x),
    .out_m_o      (out_m),
    .out_det_re_o (det_re),
    .out_det_im_o (det_im),
    .out_ovf_o    (ovf),
    .out_sing_o   (sing)
  );

  // A singular result keeps a matrix whose determinant is zero
  a_sing_det_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (det_re == '0) && (det_im == '0))
    else $error("singular result with nonzero determinant");

  // An accepted request keeps the input closed on the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // Products are issued only while a request is in work
  a_issue_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !s_axis_tready)
    else $error("multiplier issue while idle");

endmodule

// ===== tb/tb_complex_2x2_matrix_alu_core.sv =====
// Self-checking testbench for the 2x2 complex matrix unit: directed table, then random requests.
`timescale 1ns / 100ps

module tb_complex_2x2_matrix_alu_core;

  localparam int unsigned WB = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned N_RANDOM = 1730;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef logic signed [WB-1:0] word_t;
  typedef logic signed [127:0] wide_t;
  typedef word_t mat_t [8];

  typedef struct {
    cmx_pkg::func_e fn;
    logic [255:0]   data;
    logic           typed;
    logic [319:0]   t_data;
    logic [1:0]     t_user;
  } req_row_t;

  typedef struct {
    logic [319:0] data;
    logic [1:0]   user;
  } resp_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [319:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  complex_2x2_matrix_alu_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point matrix predictor
  // ---------------------------------------------------------------------------
  word_t acc_m [8];
  logic  sat_hit;
  resp_t result_q [$];
  int    mismatches = 0;

  localparam wide_t W_MAX = 128'sd2147483647;
  localparam wide_t W_MIN = -128'sd2147483648;

  function automatic word_t clip(wide_t v);
    if (v > W_MAX) begin
      sat_hit = 1'b1;
      return word_t'(W_MAX);
    end
    if (v < W_MIN) begin
      sat_hit = 1'b1;
      return word_t'(W_MIN);
    end
    return word_t'(v);
  endfunction

  // Exact product, floor-shifted by the fraction width
  function automatic wide_t fmul(word_t s, word_t t);
    wide_t p;
    p = wide_t'(s) * wide_t'(t);
    return p >>> FB;
  endfunction

  // (x*y) +/- (z*w) on complex pairs, each part saturated once
  function automatic void cplx_mac(word_t xr, word_t xi, word_t yr, word_t yi,
                                   word_t zr, word_t zi, word_t wr, word_t wi,
                                   logic minus, output word_t rr, output word_t ri);
    wide_t er, ei, sr, si;
    er = fmul(xr, yr) - fmul(xi, yi);
    ei = fmul(xr, yi) + fmul(xi, yr);
    sr = fmul(zr, wr) - fmul(zi, wi);
    si = fmul(zr, wi) + fmul(zi, wr);
    if (minus) begin
      sr = -sr;
      si = -si;
    end
    rr = clip(er + sr);
    ri = clip(ei + si);
  endfunction

  function automatic void det_of(mat_t m, output word_t dr, output word_t di);
    cplx_mac(m[0], m[1], m[6], m[7], m[2], m[3], m[4], m[5], 1'b1, dr, di);
  endfunction

  // Saturated +/- |s| * 2^(2*FB) / n, magnitude truncated
  function automatic word_t recip_part(word_t s, logic negative, wide_t n);
    wide_t mg, q;
    mg = wide_t'(s);
    if (mg < 0) mg = -mg;
    q = (mg <<< (2 * FB)) / n;
    if (negative) q = -q;
    return clip(q);
  endfunction

  // Advance the accumulator by one request and build the expected result
  function automatic resp_t predict_step(cmx_pkg::func_e fn, logic [255:0] data);
    word_t x [8];
    mat_t  cur, m, adj;
    word_t dr, di, rr, ri, zw;
    wide_t n;
    logic  sing;
    resp_t r;
    sat_hit = 1'b0;
    sing = 1'b0;
    zw = '0;
    for (int i = 0; i < 8; i++) begin
      x[i] = data[32*i +: 32];
      cur[i] = acc_m[i];
      m[i] = acc_m[i];
    end
    case (fn)
      cmx_pkg::FN_LOAD: for (int i = 0; i < 8; i++) m[i] = x[i];
      cmx_pkg::FN_ADD:
        for (int i = 0; i < 8; i++) m[i] = clip(wide_t'(cur[i]) + wide_t'(x[i]));
      cmx_pkg::FN_SUB:
        for (int i = 0; i < 8; i++) m[i] = clip(wide_t'(cur[i]) - wide_t'(x[i]));
      cmx_pkg::FN_MUL: begin
        for (int rw = 0; rw < 2; rw++) begin
          for (int k = 0; k < 2; k++) begin
            cplx_mac(cur[4*rw], cur[4*rw+1], x[2*k], x[2*k+1],
                     cur[4*rw+2], cur[4*rw+3], x[4+2*k], x[5+2*k],
                     1'b0, m[2*(2*rw+k)], m[2*(2*rw+k)+1]);
          end
        end
      end
      cmx_pkg::FN_CSC: begin
        for (int i = 0; i < 8; i += 2)
          cplx_mac(cur[i], cur[i+1], x[0], x[1], zw, zw, zw, zw, 1'b0, m[i], m[i+1]);
      end
      cmx_pkg::FN_RSC: for (int i = 0; i < 8; i++) m[i] = clip(fmul(cur[i], x[0]));
      cmx_pkg::FN_DET: ;
      default: begin
        det_of(cur, dr, di);
        if (dr == 0 && di == 0) begin
          sing = 1'b1;
        end else begin
          n = wide_t'(dr) * wide_t'(dr) + wide_t'(di) * wide_t'(di);
          rr = recip_part(dr, dr < 0, n);
          ri = recip_part(di, di > 0, n);
          adj[0] = cur[6];
          adj[1] = cur[7];
          adj[6] = cur[0];
          adj[7] = cur[1];
          for (int i = 2; i < 6; i++) adj[i] = clip(-wide_t'(cur[i]));
          for (int i = 0; i < 8; i += 2)
            cplx_mac(adj[i], adj[i+1], rr, ri, zw, zw, zw, zw, 1'b0, m[i], m[i+1]);
        end
      end
    endcase
    for (int i = 0; i < 8; i++) acc_m[i] = m[i];
    det_of(m, dr, di);
    for (int i = 0; i < 8; i++) r.data[32*i +: 32] = m[i];
    r.data[8*32 +: 32] = dr;
    r.data[9*32 +: 32] = di;
    r.user = {sing, sat_hit};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [255:0] pack_mat(word_t ar, word_t ai, word_t br, word_t bi,
                                            word_t cr, word_t ci, word_t dr, word_t di);
    return {di, dr, ci, cr, bi, br, ai, ar};
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return word_t'(W_MAX);
          1: return word_t'(W_MIN);
          2: return '0;
          3: return -1;
          4: return 32'sd65536;
          default: return -32'sd65536;
        endcase
      end
      1, 2: return word_t'($urandom);
      default: return word_t'($signed({1'b0, 31'($urandom_range(0, 524288))}) - 262144);
    endcase
  endfunction

  function automatic cmx_pkg::func_e rand_func();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 20) return cmx_pkg::FN_LOAD;
    return cmx_pkg::func_e'($urandom_range(1, 7));
  endfunction

  req_row_t dir_tab [$];

  function automatic void add_row(cmx_pkg::func_e fn, logic [255:0] d);
    req_row_t row;
    row.fn = fn;
    row.data = d;
    row.typed = 1'b0;
    row.t_data = '0;
    row.t_user = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_typed(cmx_pkg::func_e fn, logic [255:0] d, logic [319:0] td,
                                    logic [1:0] tu);
    req_row_t row;
    row.fn = fn;
    row.data = d;
    row.typed = 1'b1;
    row.t_data = td;
    row.t_user = tu;
    dir_tab.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  logic        stim_done = 1'b0;

  task automatic send_req(cmx_pkg::func_e fn, logic [255:0] d, logic typed,
                          logic [319:0] td, logic [1:0] tu);
    resp_t r;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_step(fn, d);
    if (typed) begin
      r.data = td;
      r.user = tu;
    end
    result_q.push_back(r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    word_t mx, mn, one;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= cmx_pkg::FN_LOAD;
    mx  = word_t'(W_MAX);
    mn  = word_t'(W_MIN);
    one = 32'sd65536;
    for (int i = 0; i < 8; i++) acc_m[i] = '0;
    acc_m[0] = one;
    acc_m[6] = one;

    // Identity after reset, determinant one
    add_typed(cmx_pkg::FN_DET, '1,
              {32'sd0, one, 32'sd0, one, 128'd0, 32'sd0, one}, 2'b00);
    add_row(cmx_pkg::FN_LOAD, pack_mat(mx, mx, mx, mx, mx, mx, mx, mx));
    add_row(cmx_pkg::FN_ADD, pack_mat(mx, mx, mx, mx, mx, mx, mx, mx));
    add_row(cmx_pkg::FN_SUB, pack_mat(mn, mn, mn, mn, mn, mn, mn, mn));
    add_row(cmx_pkg::FN_MUL, pack_mat(mx, mn, mn, mx, mx, mx, mn, mn));
    add_row(cmx_pkg::FN_LOAD, pack_mat(mn, mn, mn, mn, mn, mn, mn, mn));
    add_row(cmx_pkg::FN_MUL, pack_mat(mn, mn, mn, mn, mn, mn, mn, mn));
    add_row(cmx_pkg::FN_LOAD,
            pack_mat(one, one, 32'sd3, -32'sd7, 32'sd99, one, -one, 32'sd5));
    add_row(cmx_pkg::FN_CSC, pack_mat(-one, one, mx, mn, mx, mn, mx, mn));
    add_row(cmx_pkg::FN_RSC, pack_mat(mn, mx, 0, 0, 0, 0, 0, 0));
    add_row(cmx_pkg::FN_INV, '1);
    // Singular: zero matrix stays zero
    add_row(cmx_pkg::FN_LOAD, '0);
    add_typed(cmx_pkg::FN_INV, '1, '0, 2'b10);
    add_row(cmx_pkg::FN_LOAD, pack_mat(2 * one, 0, 0, 0, 0, 0, 0, one));
    add_row(cmx_pkg::FN_INV, '0);
    add_row(cmx_pkg::FN_INV, '0);
    // Adjugate negation of the most negative word
    add_row(cmx_pkg::FN_LOAD, pack_mat(one, 0, mn, 0, mn, 0, one, 0));
    add_row(cmx_pkg::FN_INV, '0);
    // Tiny entries whose product floors to a zero determinant give a singular inverse
    add_row(cmx_pkg::FN_LOAD, pack_mat(32'sd1, 0, 0, 0, 0, 0, 32'sd256, 0));
    add_row(cmx_pkg::FN_INV, '0);
    add_row(cmx_pkg::FN_LOAD, pack_mat(0, one, one, 0, 0, -one, one, one));
    add_row(cmx_pkg::FN_INV, '0);
    add_row(cmx_pkg::FN_RSC, pack_mat(-one, 0, 0, 0, 0, 0, 0, 0));
    add_row(cmx_pkg::FN_DET, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_req(dir_tab[i].fn, dir_tab[i].data, dir_tab[i].typed,
               dir_tab[i].t_data, dir_tab[i].t_user);

    for (int i = 0; i < N_RANDOM; i++)
      send_req(rand_func(), pack_mat(rand_word(), rand_word(), rand_word(), rand_word(),
                                     rand_word(), rand_word(), rand_word(), rand_word()),
               1'b0, '0, '0);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for stray results
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    stim_done = 1'b1;
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern and result check
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  string       nm [10] = '{"a_re", "a_im", "b_re", "b_im", "c_re", "c_im",
                           "d_re", "d_im", "det_re", "det_im"};

  task automatic note_mismatch(string what, logic [31:0] e, logic [31:0] a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", what, e, a);
  endtask

  initial m_axis_tready = 1'b0;

  always @(posedge clk_i) begin
    resp_t ex;
    // Hold a stall mode for a while, then pick another
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (mode_left[2:0] != 3'd0);
    endcase
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected");
      end else begin
        ex = result_q.pop_front();
        for (int i = 0; i < 10; i++)
          if (ex.data[32*i +: 32] !== m_axis_tdata[32*i +: 32])
            note_mismatch(nm[i], ex.data[32*i +: 32], m_axis_tdata[32*i +: 32]);
        if (ex.user[0] !== m_axis_tuser[0])
          note_mismatch("overflow", 32'(ex.user[0]), 32'(m_axis_tuser[0]));
        if (ex.user[1] !== m_axis_tuser[1])
          note_mismatch("singular", 32'(ex.user[1]), 32'(m_axis_tuser[1]));
      end
    end
  end

  // Watchdog on cycles without any request or result moving
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
